### hdl/ppmf_pkg.sv
// Package for the proximity peak meter filter: shared constants, codes and types.
// No dependencies.
package ppmf_pkg;
  localparam int FIRST_TAPS_DEF  = 64;
  localparam int SECOND_TAPS_DEF = 64;
  localparam int PULSE_TAPS_DEF  = 8;
  localparam int SMOOTH_TAPS_DEF = 4;

  localparam logic [3:0] IGNORE_RESET = 4'd2;
  localparam logic [7:0] JUMP_RESET   = 8'd10;
  localparam logic [7:0] FULL_SCALE   = 8'd255;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_PULSE  = 2'd1,
    ACT_START  = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_FILT  = 2'd2,
    MODE_CAL   = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_FILT  = 2'd1;
  localparam logic [1:0] KIND_CAL   = 2'd2;
  localparam logic [1:0] START_BAD  = 2'd3;

  localparam logic CFG_IGNORE = 1'b0;
  localparam logic CFG_JUMP   = 1'b1;
endpackage

### hdl/ppmf_in_if.sv
// Input channel interface: valid/ready handshake with the input fields.
// No dependencies.
interface ppmf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] meter_sample;
  logic [7:0] temp_a;
  logic [7:0] temp_b;
  logic [1:0] start_mode;
  modport source (output valid, action, meter_sample, temp_a, temp_b, start_mode, input ready);
  modport sink (input valid, action, meter_sample, temp_a, temp_b, start_mode, output ready);
endinterface

### hdl/ppmf_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// No dependencies.
interface ppmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reading;
  logic [7:0] temp_a_out;
  logic [7:0] temp_b_out;
  logic [1:0] reading_kind;
  modport source (output valid, reading, temp_a_out, temp_b_out, reading_kind, input ready);
  modport sink (input valid, reading, temp_a_out, temp_b_out, reading_kind, output ready);
endinterface

### hdl/ppmf_cfg_if.sv
// Configuration write channel interface: register index and data.
// No dependencies.
interface ppmf_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/proximity_peak_meter_filter.sv
// Top level of the proximity peak meter filter.
// Depends on ppmf_pkg, the three channel interfaces and ppmf_box.
// An accepted pulse transaction that yields a result has it in the output register in the next cycle.
// Throughput: one transaction per cycle unless a stalled result holds off the input; each filter
// updates its flip-flop window and running sum in a single step, so nothing iterates.
// Reset: synchronous, active low; clears sums, fill phases, peak, mode, counts, output valid and
// config registers to their defaults; window contents stay undefined until written by a fill phase.
module proximity_peak_meter_filter #(
  parameter int FIRST_TAPS  = ppmf_pkg::FIRST_TAPS_DEF,
  parameter int SECOND_TAPS = ppmf_pkg::SECOND_TAPS_DEF,
  parameter int PULSE_TAPS  = ppmf_pkg::PULSE_TAPS_DEF,
  parameter int SMOOTH_TAPS = ppmf_pkg::SMOOTH_TAPS_DEF
) (
  input logic clk,
  input logic rst_n,
  ppmf_in_if.sink    in_ch,
  ppmf_out_if.source out_ch,
  ppmf_cfg_if.sink   cfg_ch
);
  logic [3:0] ignore_r;
  logic [7:0] jump_r;
  logic [7:0] peak_r, peak_nxt;
  logic [4:0] skip_r;
  ppmf_pkg::mode_t mode_r;
  logic [7:0] prev_r;
  logic       prev_ok_r;
  logic [7:0] ta_r, tb_r;
  logic       ovalid_r;
  logic [7:0] oread_r, oa_r, ob_r;
  logic [1:0] okind_r;

  logic acc, is_smp, is_pulse, is_start, is_end, start_ok, live_pulse;
  logic a_ok, b_ok, p_ok, s_ok;
  logic [7:0] a_avg, b_avg, p_avg, s_avg, inv;
  logic clamp, res_fire, filt_fire;
  logic [8:0] hi_lim, lo_sum;

  // Output register frees whenever taken or empty: accept on either.
  assign in_ch.ready  = !ovalid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign acc      = in_ch.valid && in_ch.ready;
  assign is_smp   = acc && in_ch.action == ppmf_pkg::ACT_SAMPLE;
  assign is_pulse = acc && in_ch.action == ppmf_pkg::ACT_PULSE;
  assign is_start = acc && in_ch.action == ppmf_pkg::ACT_START;
  assign is_end   = acc && in_ch.action == ppmf_pkg::ACT_END;
  assign start_ok = is_start && in_ch.start_mode != ppmf_pkg::START_BAD;
  // Pulses beyond the ignore window feed the peak into the pulse filter.
  assign live_pulse = is_pulse && skip_r > {1'b0, ignore_r};

  // Cascade: the second filter only sees running averages of the first.
  ppmf_box #(.TAPS(FIRST_TAPS)) u_first (
    .clk, .rst_n, .clear(1'b0), .feed(is_smp), .value(in_ch.meter_sample),
    .avg_ok(a_ok), .avg(a_avg));
  ppmf_box #(.TAPS(SECOND_TAPS)) u_second (
    .clk, .rst_n, .clear(1'b0), .feed(is_smp && a_ok), .value(a_avg),
    .avg_ok(b_ok), .avg(b_avg));
  // Ignored pulses restart the pulse filter.
  ppmf_box #(.TAPS(PULSE_TAPS)) u_pulse (
    .clk, .rst_n, .clear(is_pulse && !live_pulse), .feed(live_pulse), .value(peak_r),
    .avg_ok(p_ok), .avg(p_avg));
  // Smoothing restarts on a filtered or calibration start.
  ppmf_box #(.TAPS(SMOOTH_TAPS)) u_smooth (
    .clk, .rst_n, .clear(start_ok && in_ch.start_mode != ppmf_pkg::KIND_PLAIN),
    .feed(live_pulse && p_ok && (mode_r == ppmf_pkg::MODE_FILT || mode_r == ppmf_pkg::MODE_CAL)),
    .value(p_avg), .avg_ok(s_ok), .avg(s_avg));

  assign inv = ppmf_pkg::FULL_SCALE - b_avg;

  always_comb begin
    peak_nxt = peak_r;
    if (is_smp && a_ok && b_ok && mode_r != ppmf_pkg::MODE_IDLE && inv > peak_r) begin
      peak_nxt = inv;
    end else if (live_pulse) begin
      peak_nxt = '0;
    end
  end

  // Jump clamp compares in nine bits so the limit never wraps.
  assign hi_lim = {1'b0, prev_r} + {1'b0, jump_r};
  assign lo_sum = {1'b0, s_avg} + {1'b0, jump_r};
  assign clamp  = prev_ok_r && ({1'b0, s_avg} > hi_lim || lo_sum < {1'b0, prev_r});

  // A result leaves for plain pulses, and for smoothed pulses once smoothing runs.
  assign filt_fire = live_pulse && p_ok && mode_r == ppmf_pkg::MODE_FILT && s_ok;
  assign res_fire  = live_pulse && p_ok &&
                     (mode_r == ppmf_pkg::MODE_PLAIN ||
                      ((mode_r == ppmf_pkg::MODE_FILT || mode_r == ppmf_pkg::MODE_CAL) && s_ok));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r  <= ppmf_pkg::IGNORE_RESET;
      jump_r    <= ppmf_pkg::JUMP_RESET;
      peak_r    <= '0;
      skip_r    <= '0;
      mode_r    <= ppmf_pkg::MODE_IDLE;
      prev_r    <= '0;
      prev_ok_r <= 1'b0;
      ta_r      <= '0;
      tb_r      <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          ppmf_pkg::CFG_IGNORE: ignore_r <= cfg_ch.data[3:0];
          ppmf_pkg::CFG_JUMP:   jump_r   <= cfg_ch.data;
          default: ;
        endcase
      end
      peak_r <= peak_nxt;
      if (is_smp) begin
        ta_r <= in_ch.temp_a;
        tb_r <= in_ch.temp_b;
      end
      if (start_ok) begin
        mode_r <= ppmf_pkg::mode_t'(in_ch.start_mode + 2'd1);
        skip_r <= '0;
        if (in_ch.start_mode == ppmf_pkg::KIND_FILT) prev_ok_r <= 1'b0;
      end else if (is_end) begin
        mode_r <= ppmf_pkg::MODE_IDLE;
      end
      if (is_pulse && !live_pulse) skip_r <= skip_r + 5'd1;
      // Hold the result until taken; drop it once the sink takes it.
      ovalid_r <= res_fire || (ovalid_r && !out_ch.ready);
      if (filt_fire) begin
        if (!clamp) prev_r <= s_avg;
        prev_ok_r <= 1'b1;
      end
    end
  end

  // Result payload follows the mode active at the pulse.
  always_ff @(posedge clk) begin
    if (live_pulse && p_ok) begin
      unique case (mode_r)
        ppmf_pkg::MODE_FILT: begin
          oread_r <= clamp ? prev_r : s_avg;
          oa_r <= ta_r; ob_r <= tb_r; okind_r <= ppmf_pkg::KIND_FILT;
        end
        ppmf_pkg::MODE_CAL: begin
          oread_r <= s_avg; oa_r <= '0; ob_r <= '0; okind_r <= ppmf_pkg::KIND_CAL;
        end
        default: begin
          oread_r <= p_avg; oa_r <= ta_r; ob_r <= tb_r; okind_r <= ppmf_pkg::KIND_PLAIN;
        end
      endcase
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.reading      = oread_r;
  assign out_ch.temp_a_out   = oa_r;
  assign out_ch.temp_b_out   = ob_r;
  assign out_ch.reading_kind = okind_r;

  a_skip_cap: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= 5'd16)
    else $error("skip count passed ignore window");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");
  a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
    live_pulse |=> peak_r == '0)
    else $error("peak not cleared by pulse");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == ppmf_pkg::MODE_IDLE && !ovalid_r && !start_ok |=> !ovalid_r)
    else $error("result while idle");
endmodule

### hdl/ppmf_box.sv
// Boxcar average with fill phase: window in flip-flops, running sum.
// Depends on nothing but its parameters.
module ppmf_box #(
  parameter int TAPS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  logic       feed,
  input  logic [7:0] value,
  output logic       avg_ok,
  output logic [7:0] avg
);
  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW = $clog2(TAPS + 2);
  localparam int SW = $clog2(TAPS * 255 + 1);

  logic [7:0]    win_r [TAPS];
  logic [7:0]    old_r;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r;
  logic          filling, dropping;

  assign filling  = fill_r < FW'(TAPS);
  assign dropping = fill_r == FW'(TAPS);
  assign sum_nxt  = sum_r - SW'(old_r) + SW'(value);
  assign avg_ok   = !filling && !dropping;
  assign avg      = 8'(sum_nxt / TAPS);

  always_comb begin
    head_nxt = head_r;
    if (!rst_n || clear) begin
      head_nxt = '0;
    end else if (feed && dropping) begin
      head_nxt = '0;
    end else if (feed && avg_ok) begin
      head_nxt = (head_r == IW'(TAPS - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (!rst_n || clear) begin
      sum_r  <= '0;
      fill_r <= '0;
    end else if (feed) begin
      if (filling) begin
        sum_r  <= sum_r + SW'(value);
        fill_r <= fill_r + 1'b1;
      end else if (dropping) begin
        fill_r <= fill_r + 1'b1;
      end else begin
        sum_r  <= sum_nxt;
      end
    end
  end

  // Prefetch the oldest entry at the next head so the drop-out value is registered.
  always_ff @(posedge clk) begin
    old_r <= win_r[head_nxt];
    if (feed && filling) begin
      win_r[fill_r[IW-1:0]] <= value;
    end else if (feed && avg_ok) begin
      win_r[head_r] <= value;
    end
  end
endmodule
